// ===== hdl/rr_pkg.sv =====
package rr_pkg;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV  = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	localparam int MOD_BITS = 63;

	// Operation codes for the shared division unit.
	typedef enum logic [1:0] {
		DOP_DIV = 2'd0,
		DOP_MUL = 2'd1
	} div_op_t;

	typedef struct packed {
		logic    start;
		div_op_t op;
	} div_ctl_t;

endpackage

// ===== hdl/rr_divider.sv =====
module rr_divider import rr_pkg::*; #(
	parameter int W = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	input  div_ctl_t     ctl,
	input  logic [W-1:0] opa,
	input  logic [W-1:0] opb,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	// DOP_DIV: restoring division, one quotient bit per cycle.
	// DOP_MUL: shift-add product opa*opb modulo 2^W, one bit per cycle.
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  q_q;
	logic [W:0]    r_q;
	logic [CW-1:0] cnt_q;
	div_op_t       op_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W-1:0]  madd;

	always_comb begin
		trial = {r_q[W-1:0], a_q[W-1]} - {1'b0, b_q};
		madd  = q_q << 1;
		if (a_q[W-1]) begin
			madd = (q_q << 1) + b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			a_q  <= opa;
			b_q  <= opb;
			q_q  <= '0;
			r_q  <= '0;
			op_q <= ctl.op;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			case (op_q)
				DOP_DIV: begin
					if (!trial[W]) begin
						r_q <= trial;
						q_q <= {q_q[W-2:0], 1'b1};
					end else begin
						r_q <= {r_q[W-1:0], a_q[W-1]};
						q_q <= {q_q[W-2:0], 1'b0};
					end
				end
				default: begin
					q_q <= madd;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q[W-1:0];

endmodule

// ===== hdl/rational_reconstruction_unit.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_stall        residue
// out       output     out_valid / out_stall      status, numerator, denominator, gcd_factor
// cfg       input      cfg_we                     cfg_data (modulus)
//
// Each pass of the shared shift-subtract unit is a start state followed by a wait state
// that lasts until the unit signals done. A Euclid step uses two passes (quotient, then
// product); each gcd step at the end is one pass.
// Division, the cofactor product and the gcd remainders go through the one shared unit.
// Reset clears the sequencer and sets the modulus to 2. The result is held in an
// output register; the input side is stalled from acceptance until it is taken.
module rational_reconstruction_unit import rr_pkg::*; #(
	parameter int WORD_BITS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [62:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] residue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] numerator,
	output logic [30:0] denominator,
	output logic [62:0] gcd_factor
);

	localparam int W = WORD_BITS + 1;  // room for signed cofactors

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_DIVW  = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_MULW  = 9'b000100000,
		S_GCD   = 9'b001000000,
		S_GCDW  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  n_q, u3_q, v3_q, u1_q, v1_q, qt_q, ga_q, gb_q, qv_q;
	logic [62:0]   mod_q;
	logic          opp_q, neg_q;
	logic [1:0]    st_q;
	logic [31:0]   num_q;
	logic [30:0]   den_q;
	logic [62:0]   g_q;
	logic          ov_q;

	div_ctl_t      dctl;
	logic [W-1:0]  dopa, dopb, dquo, drem;
	logic          dbusy, ddone;

	logic [W-1:0]  nmod, amag, half, u1mag;
	logic          u1big, u3big;

	rr_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .opa(dopa), .opb(dopb),
		.busy(dbusy), .done(ddone), .quo(dquo), .rem(drem)
	);

	assign nmod  = {1'b0, WORD_BITS'(mod_q)};
	assign amag  = W'(residue[63] ? (64'd0 - residue) : residue);
	assign half  = n_q - (n_q >> 1);
	assign u1mag = u1_q[W-1] ? (W'(0) - u1_q) : u1_q;

	// 2*m*m >= n; m*m is formed only for m below 2^32, so the product fits.
	function automatic logic sq_ge(input logic [W-1:0] m, input logic [W-1:0] h);
		logic [63:0] mm;
		logic [31:0] ml;
		ml = 32'(m);
		mm = {32'd0, ml} * {32'd0, ml};
		if (W > 32 && (m >> 32) != '0) begin
			return 1'b1;
		end
		return mm >= 64'(h);
	endfunction

	assign u1big = sq_ge(u1mag, half);
	assign u3big = sq_ge(u3_q, half);

	// The shared unit is started only when a pass actually follows, so it is
	// always idle when the next pass or the next item begins.
	always_comb begin
		dctl.start = 1'b0;
		dctl.op    = DOP_DIV;
		dopa       = u3_q;
		dopb       = v3_q;
		case (state_q)
			S_DIV: begin
				dctl.start = !u1big && u3big && (v3_q != '0);
			end
			S_MUL: begin
				dctl.start = 1'b1;
				dctl.op    = DOP_MUL;
				dopa       = qt_q;
				dopb       = v1_q;
			end
			S_GCD: begin
				dctl.start = (gb_q != '0);
				dopa       = ga_q;
				dopb       = gb_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mod_q   <= 63'd2;
		end else begin
			if (cfg_we) begin
				mod_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (ov_q || u3_q >= n_q || u3_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (u1big) begin
						state_q <= S_OUT;
					end else if (!u3big) begin
						state_q <= S_GCD;
					end else if (v3_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIVW;
					end
				end
				S_DIVW: if (ddone) state_q <= S_MUL;
				S_MUL:  state_q <= S_MULW;
				S_MULW: if (ddone) state_q <= S_DIV;
				S_GCD: begin
					if (gb_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_GCDW;
					end
				end
				S_GCDW: if (ddone) state_q <= S_GCD;
				S_OUT:  if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// In S_CHECK u3_q holds the residue magnitude; folding happens on entry to S_DIV.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= nmod;
				u3_q  <= amag;
				opp_q <= residue[63];
				ov_q  <= (residue[63] && residue[62:0] == '0) ||
					(residue[63:WORD_BITS] != '0 && !residue[63]) ||
					(residue[63] && (64'd0 - residue) >> WORD_BITS != '0);
				st_q  <= ST_NOT_FOUND;
				num_q <= '0;
				den_q <= '0;
				g_q   <= '0;
			end
			S_CHECK: begin
				if (ov_q || u3_q >= n_q) begin
					st_q <= ST_RANGE;
				end else if (u3_q == '0) begin
					st_q  <= ST_FOUND;
					den_q <= 31'd1;
				end else begin
					v3_q <= (u3_q >= half) ? n_q - u3_q : u3_q;
					if (u3_q >= half) opp_q <= !opp_q;
					u3_q <= n_q;
					u1_q <= '0;
					v1_q <= W'(1);
				end
			end
			S_DIV: begin
				if (!u1big && !u3big) begin
					neg_q <= u1_q[W-1];
					ga_q  <= u1mag;
					gb_q  <= n_q;
				end
			end
			S_DIVW: begin
				if (ddone) begin
					qt_q <= dquo;
					qv_q <= drem;
				end
			end
			S_MULW: begin
				if (ddone) begin
					u3_q <= v3_q;
					v3_q <= qv_q;
					v1_q <= u1_q - dquo;
					u1_q <= v1_q;
				end
			end
			S_GCD: begin
				if (gb_q == '0) begin
					if (ga_q != W'(1)) begin
						st_q <= ST_ZERO_DIV;
						g_q  <= 63'(ga_q);
					end else begin
						st_q  <= ST_FOUND;
						den_q <= 31'(u1mag);
						num_q <= (neg_q ^ opp_q) ? 32'd0 - 32'(u3_q) : 32'(u3_q);
					end
				end
			end
			S_GCDW: begin
				if (ddone) begin
					ga_q <= gb_q;
					gb_q <= drem;
				end
			end
			default: ;
		endcase
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign status      = st_q;
	assign numerator   = num_q;
	assign denominator = den_q;
	assign gcd_factor  = g_q;

endmodule

// ===== tb/tb_rational_reconstruction_unit.sv =====
module tb_rational_reconstruction_unit import rr_pkg::*;;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] num;
		logic [30:0] den;
		logic [62:0] g;
	} recon_t;

	class recon_board;
		recon_t pending[$];
		int errors = 0;

		function void note(recon_t r);
			pending.push_back(r);
		endfunction

		function void check(recon_t got);
			recon_t e;
			if (pending.size() == 0) begin
				$error("unexpected item: status %0d", got.st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, got.st);
				errors++;
			end
			if (got.num !== e.num) begin
				$error("numerator expected %0d actual %0d", $signed(e.num), $signed(got.num));
				errors++;
			end
			if (got.den !== e.den) begin
				$error("denominator expected %0d actual %0d", e.den, got.den);
				errors++;
			end
			if (got.g !== e.g) begin
				$error("gcd_factor expected %0d actual %0d", e.g, got.g);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [62:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [63:0] residue = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [31:0] numerator;
	logic [30:0] denominator;
	logic [62:0] gcd_factor;

	recon_board board = new();
	logic [62:0] cur_mod = 63'd2;
	int idle_cycles = 0;
	bit hold_off = 0;

	rational_reconstruction_unit i_dut (.*);

	always #6 clk = ~clk;

	function automatic bit twice_sq_ge(logic [63:0] m, logic [63:0] n);
		if (m > 64'hFFFF_FFFF) return 1;
		return m * m >= n - (n >> 1);
	endfunction

	function automatic logic [63:0] mag(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic recon_t reconstruct(logic [63:0] a, logic [62:0] m);
		logic [63:0] n, v3, u3, u1, v1, q, t, d, r;
		bit opp, neg;
		recon_t res;
		n = {1'b0, m};
		opp = a[63];
		v3 = mag(a);
		res = '0;
		res.st = ST_NOT_FOUND;
		if (v3 >= n) begin
			res.st = ST_RANGE;
		end else if (v3 == 0) begin
			res.st = ST_FOUND;
			res.den = 31'd1;
		end else begin
			if (v3 >= n - (n >> 1)) begin
				v3 = n - v3;
				opp = !opp;
			end
			u1 = 0; u3 = n; v1 = 1;
			forever begin
				if (twice_sq_ge(mag(u1), n)) break;
				if (!twice_sq_ge(u3, n)) begin
					neg = u1[63];
					q = mag(u1);
					d = gcd64(q, n);
					if (d != 1) begin
						res.st = ST_ZERO_DIV;
						res.g = d[62:0];
					end else begin
						res.st = ST_FOUND;
						res.den = q[30:0];
						t = (neg ^ opp) ? -u3 : u3;
						res.num = t[31:0];
					end
					break;
				end
				if (v3 == 0) break;
				q = u3 / v3;
				r = u3 % v3;
				t = v1;
				u3 = v3;
				v3 = r;
				v1 = u1 - t * q;
				u1 = t;
			end
		end
		return res;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	task automatic send(logic [63:0] a);
		@(negedge clk);
		in_valid <= 1;
		residue <= a;
		do @(posedge clk); while (in_stall);
		board.note(reconstruct(a, cur_mod));
		@(negedge clk);
		in_valid <= 0;
		residue <= $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
		repeat (gap_len()) @(negedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_modulus(logic [62:0] m);
		drain();
		@(negedge clk);
		cfg_we <= 1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 0;
		cur_mod = m;
	endtask

	function automatic logic [63:0] rand_residue(logic [62:0] m);
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1: v = {1'b0, m} - $urandom_range(0, 3);
			default: v = {$urandom, $urandom} % ({1'b0, m} + 1);
		endcase
		if ($urandom_range(0, 2) == 0) v = {$urandom, $urandom} % 64'd50000;
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// Receiver: random stalls, plus one long hold-off requested by the sender.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			if ($urandom_range(0, 30) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(10, 80)) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check('{status, numerator, denominator, gcd_factor});
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 40000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [62:0] mods[6];
		logic [62:0] m;
		mods = '{63'd2, 63'd1, 63'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd1000003, 63'd360};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// Reset modulus of two: zero, one and out-of-range residues.
		send(0); send(1); send(64'h8000_0000_0000_0000);
		foreach (mods[k]) begin
			set_modulus(mods[k]);
			send(0);
			send(1);
			send(-64'sd1);
			send({1'b0, mods[k]});
			send({1'b0, mods[k]} - 1);
			send(64'h8000_0000_0000_0000);
			send(64'h7FFF_FFFF_FFFF_FFFF);
			if (k == 4) begin
				send(64'd500002);
				send(64'd333335);
			end
		end
		// Fill the block while the receiver holds off.
		hold_off = 1;
		repeat (4) send(rand_residue(cur_mod));
		for (int i = 0; i < 90; i++) begin
			if (i % 15 == 0) begin
				case ($urandom_range(0, 3))
					0: m = {$urandom, $urandom} >> 1;
					1: m = $urandom_range(2, 100000);
					2: m = ({$urandom, $urandom} >> $urandom_range(1, 62)) | 63'd2;
					default: m = 63'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 10);
				endcase
				set_modulus(m);
			end
			if (i == 45) drain();
			send(rand_residue(cur_mod));
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
